// ===== rtl/rksi_pkg.sv =====
// ----------------------------------------------------------------------------
// Rolling k-mer slot indexer package
// Shared types, field widths, character codes and register indexes.
// ----------------------------------------------------------------------------
package rksi_pkg;

    localparam int BASE_W      = 8;
    localparam int CHROM_W     = 16;
    localparam int SLOT_W      = 32;
    localparam int BLKIDX_W    = 24;
    localparam int OFFSET_W    = 8;
    localparam int COORD_W     = 32;
    localparam int KLEN_W      = 5;
    localparam int LIMIT_W     = 25;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 25;

    localparam int DEF_BLOCK_SPAN   = 256;
    localparam int DEF_MAX_KMER_LEN = 16;

    localparam logic [KLEN_W-1:0]  KMER_LEN_RESET    = 5'd12;
    localparam logic [LIMIT_W-1:0] BLOCK_LIMIT_RESET = 25'd16777216;

    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 1'b1;

    localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
    localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [CHROM_W-1:0] chrom;
        logic               first_of_chrom;
    } t_in_item;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic [BLKIDX_W-1:0] block_index;
        logic [OFFSET_W-1:0] offset;
        logic                new_block;
        logic [COORD_W-1:0]  block_start;
        logic [CHROM_W-1:0]  block_chrom;
        logic                overflow;
    } t_out_item;

endpackage

// ===== rtl/rksi_stream_if.sv =====
// ----------------------------------------------------------------------------
// Rolling k-mer slot indexer stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface rksi_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rolling_kmer_slot_indexer.sv =====
// ----------------------------------------------------------------------------
// Rolling k-mer slot indexer
// Rolling 2-bit k-mer encoder with block and offset bookkeeping.
// ----------------------------------------------------------------------------
// One nucleotide byte is taken per clock cycle on the input channel, with no
// gaps required between transfers. The window, block and coordinate state is
// updated in the cycle of the transfer; a result goes to the output register,
// or to the skid stage while that register waits. The one-entry skid stage lets
// the input keep running while a result waits; the input stalls only once both
// are full. Once the block table overflows, every further item yields an
// overflow-only result until reset.
module rolling_kmer_slot_indexer
    import rksi_pkg::*;
#(
    parameter int BLOCK_SPAN   = DEF_BLOCK_SPAN,
    parameter int MAX_KMER_LEN = DEF_MAX_KMER_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rksi_stream_if.sink           i_in,
    rksi_stream_if.source         o_out
);

    localparam int OFF_W = $clog2(BLOCK_SPAN);
    localparam int RUN_W = $clog2(MAX_KMER_LEN + 1);
    localparam logic [KLEN_W-1:0] K_MAX   = KLEN_W'(MAX_KMER_LEN);
    localparam logic [OFF_W:0]    SPAN_EX = (OFF_W + 1)'(BLOCK_SPAN);

    logic [KLEN_W-1:0]   r_kmer_len;
    logic [LIMIT_W-1:0]  r_block_limit;
    logic [SLOT_W-1:0]   r_code,    n_code;
    logic [RUN_W-1:0]    r_run,     n_run;
    logic [COORD_W-1:0]  r_wstart,  n_wstart;
    logic [OFF_W-1:0]    r_off,     n_off;
    logic [BLKIDX_W-1:0] r_blk,     n_blk;
    logic                r_halted,  n_halted;
    t_out_item           r_out,     r_skid;
    logic                r_out_v,   r_skid_v;

    logic [KLEN_W-1:0]   k_eff;
    logic [5:0]          k_bits;
    logic [32:0]         mask_ex;
    logic [1:0]          base_code;
    logic                base_ok;
    logic [RUN_W-1:0]    run_base;
    logic [SLOT_W-1:0]   code_base;
    logic [COORD_W-1:0]  wstart_base;
    logic [SLOT_W-1:0]   code_shift;
    logic                win_full;
    logic [OFF_W:0]      acc;
    logic                acc_wrap;
    logic                table_full;
    t_out_item           res;
    logic                produce;
    logic                in_acc;
    logic                push;
    logic                out_take;

    assign in_acc   = i_in.valid & i_in.ready;
    assign push     = in_acc & produce;
    assign out_take = r_out_v & o_out.ready;

    assign i_in.ready    = ~r_skid_v;
    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

    always_comb begin
        if (r_kmer_len == '0) begin
            k_eff = KLEN_W'(1);
        end else if (r_kmer_len > K_MAX) begin
            k_eff = K_MAX;
        end else begin
            k_eff = r_kmer_len;
        end
        k_bits  = {k_eff, 1'b0};
        mask_ex = (33'd1 << k_bits) - 33'd1;
    end

    always_comb begin
        base_ok   = 1'b1;
        base_code = CODE_A;
        case (i_in.payload.base)
            CHAR_A:  base_code = CODE_A;
            CHAR_C:  base_code = CODE_C;
            CHAR_G:  base_code = CODE_G;
            CHAR_T:  base_code = CODE_T;
            default: base_ok   = 1'b0;
        endcase
    end

    always_comb begin
        if (i_in.payload.first_of_chrom) begin
            run_base    = '0;
            code_base   = '0;
            wstart_base = '0;
        end else begin
            run_base    = r_run;
            code_base   = r_code;
            wstart_base = r_wstart;
        end
        code_shift = ({2'b00, code_base[SLOT_W-1:2]}
                      | (SLOT_W'(base_code) << (k_bits - 6'd2))) & mask_ex[SLOT_W-1:0];
        win_full   = base_ok && (KLEN_W'(run_base) >= (k_eff - KLEN_W'(1)));
    end

    always_comb begin
        n_code     = r_code;
        n_run      = r_run;
        n_wstart   = r_wstart;
        n_off      = r_off;
        n_blk      = r_blk;
        n_halted   = r_halted;
        res        = '0;
        produce    = 1'b0;
        acc        = {1'b0, r_off};
        acc_wrap   = 1'b0;
        table_full = ({1'b0, r_blk} == (r_block_limit - LIMIT_W'(1)));
        if (r_halted) begin
            res.overflow = 1'b1;
            produce      = 1'b1;
        end else begin
            if (base_ok) begin
                n_code   = code_shift;
                n_wstart = wstart_base;
                if (win_full) begin
                    n_run           = run_base;
                    res.hit         = 1'b1;
                    res.slot        = code_shift;
                    res.block_index = r_blk;
                    res.offset      = OFFSET_W'(r_off);
                    n_wstart        = wstart_base + COORD_W'(1);
                    acc             = {1'b0, r_off} + (OFF_W + 1)'(1);
                end else begin
                    n_run = run_base + RUN_W'(1);
                end
            end else begin
                acc      = {1'b0, r_off} + (OFF_W + 1)'(run_base) + (OFF_W + 1)'(1);
                n_wstart = wstart_base + COORD_W'(run_base) + COORD_W'(1);
                n_run    = '0;
                n_code   = '0;
            end
            acc_wrap = (acc >= SPAN_EX);
            if (acc_wrap) begin
                if (table_full) begin
                    n_halted     = 1'b1;
                    res.overflow = 1'b1;
                end else begin
                    n_blk           = r_blk + BLKIDX_W'(1);
                    n_off           = OFF_W'(acc - SPAN_EX);
                    res.new_block   = 1'b1;
                    res.block_start = n_wstart - COORD_W'(n_off);
                    res.block_chrom = i_in.payload.chrom;
                end
            end else begin
                n_off = acc[OFF_W-1:0];
            end
            produce = res.hit | res.new_block | res.overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len    <= KMER_LEN_RESET;
            r_block_limit <= BLOCK_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KMER_LEN:    r_kmer_len    <= i_cfg_data[KLEN_W-1:0];
                CFG_BLOCK_LIMIT: r_block_limit <= i_cfg_data[LIMIT_W-1:0];
                default:         r_kmer_len    <= r_kmer_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code   <= '0;
            r_run    <= '0;
            r_wstart <= '0;
            r_off    <= '0;
            r_blk    <= '0;
            r_halted <= 1'b0;
        end else if (in_acc) begin
            r_code   <= n_code;
            r_run    <= n_run;
            r_wstart <= n_wstart;
            r_off    <= n_off;
            r_blk    <= n_blk;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || out_take) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= push;
            end else begin
                r_out_v  <= push;
            end
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || out_take) begin
            if (r_skid_v) begin
                r_out  <= r_skid;
                r_skid <= res;
            end else begin
                r_out  <= res;
            end
        end else if (push) begin
            r_skid <= res;
        end
    end

    // The halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // The skid stage only fills behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a result while the output register is empty");

    // The block offset always lies inside one block.
    a_offset_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_off} < SPAN_EX)
        else $error("block offset beyond the block span");

    // A window never holds more bases than the longest k-mer.
    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KLEN_W'(r_run) < K_MAX)
        else $error("run count reached the maximum k-mer length");

    // Every transfer accepted after a halt must leave the output register holding a result.
    a_halt_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_halted) |=> r_out_v)
        else $error("no result after a transfer while halted");

endmodule
